// ----- rtl/clm_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package clm_pkg;

    localparam int ROW_CHARS   = 16;
    localparam int STORE_CHARS = 32;
    localparam int IDX_W       = 5;
    localparam int POS_W       = 6;

    localparam logic [7:0] SPACE_CHAR   = 8'h20;
    localparam logic [7:0] INSTR_CLEAR  = 8'h01;
    localparam logic [7:0] INSTR_DISP   = 8'h0E;
    localparam logic [7:0] INSTR_FUNC   = 8'h38;
    localparam logic [7:0] INSTR_ENTRY  = 8'h06;
    localparam logic [7:0] INSTR_ROW1   = 8'h80;
    localparam logic [7:0] INSTR_ROW2   = 8'hC0;

    localparam logic [POS_W-1:0] ROW_END   = POS_W'(ROW_CHARS);
    localparam logic [POS_W-1:0] STORE_END = POS_W'(STORE_CHARS);

    typedef enum logic [1:0] {
        ACT_TICK  = 2'd0,
        ACT_WRITE = 2'd1,
        ACT_PRINT = 2'd2,
        ACT_CLEAR = 2'd3
    } action_t;

    typedef struct packed {
        logic [1:0]       action;
        logic [IDX_W-1:0] char_index;
        logic [7:0]       char_code;
    } item_t;

    typedef struct packed {
        logic       strobe_res;
        logic [7:0] bus_byte;
        logic       reg_select;
        logic       read_write;
        logic       busy_res;
    } result_t;

    // store update request from the sequencer
    typedef struct packed {
        logic             wr_en;
        logic             clr;
        logic [IDX_W-1:0] addr;
        logic [7:0]       data;
    } store_cmd_t;

endpackage

`default_nettype wire

// ----- rtl/clm_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface clm_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] action;
    logic [4:0] char_index;
    logic [7:0] char_code;

    modport source (output valid, output action, output char_index, output char_code,
                    input ready);
    modport sink (input valid, input action, input char_index, input char_code,
                  output ready);
endinterface

interface clm_out_if;
    logic       valid;
    logic       ready;
    logic       strobe_res;
    logic [7:0] bus_byte;
    logic       reg_select;
    logic       read_write;
    logic       busy_res;

    modport source (output valid, output strobe_res, output bus_byte, output reg_select,
                    output read_write, output busy_res, input ready);
    modport sink (input valid, input strobe_res, input bus_byte, input reg_select,
                  input read_write, input busy_res, output ready);
endinterface

`default_nettype wire

// ----- rtl/clm_store.sv -----
`timescale 1ns / 1ps
`default_nettype none

module clm_store
    import clm_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire store_cmd_t       cmd,
    input  wire logic [IDX_W-1:0] rd_addr,
    output logic [7:0]            rd_data
);

    logic [7:0] store_reg [STORE_CHARS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < STORE_CHARS; i++)
            begin
                store_reg[i] <= SPACE_CHAR;
            end
        end
        else if (cmd.clr)
        begin
            for (int i = 0; i < STORE_CHARS; i++)
            begin
                store_reg[i] <= SPACE_CHAR;
            end
        end
        else if (cmd.wr_en)
        begin
            store_reg[cmd.addr] <= cmd.data;
        end
    end

    assign rd_data = store_reg[rd_addr];

endmodule

`default_nettype wire

// ----- rtl/clm_seq.sv -----
`timescale 1ns / 1ps
`default_nettype none

module clm_seq
    import clm_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire item_t            item,
    input  wire logic             item_valid,
    output logic                  item_ready,
    output store_cmd_t            store_cmd,
    output logic [IDX_W-1:0]      rd_addr,
    input  wire logic [7:0]       rd_data,
    output result_t               res,
    output logic                  res_valid,
    input  wire logic             res_ready
);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'd0,
        ST_SET1  = 4'd1,
        ST_SET2  = 4'd2,
        ST_SET3  = 4'd3,
        ST_SET4  = 4'd4,
        ST_ADDR1 = 4'd5,
        ST_ROW1  = 4'd6,
        ST_ADDR2 = 4'd7,
        ST_ROW2  = 4'd8
    } step_t;

    step_t            step_reg, step_next, step_eff;
    logic             busy_reg, busy_next;
    logic             setup_reg, setup_next;
    logic             print_reg, print_next;
    logic [POS_W-1:0] pos_reg, pos_next, pos_inc;
    result_t          res_reg, res_next;
    logic             res_valid_reg, res_valid_next;
    logic             fire;
    logic [7:0]       char_byte;

    assign item_ready = !res_valid_reg || res_ready;
    assign fire       = item_valid && item_ready;
    assign rd_addr    = pos_reg[IDX_W-1:0];
    // positions past the store read as space
    assign char_byte  = (pos_reg >= STORE_END) ? SPACE_CHAR : rd_data;
    assign pos_inc    = pos_reg + POS_W'(1);

    always_comb
    begin
        step_next  = step_reg;
        busy_next  = busy_reg;
        setup_next = setup_reg;
        print_next = print_reg;
        pos_next   = pos_reg;
        step_eff   = step_reg;
        res_next   = res_reg;
        store_cmd  = '0;
        store_cmd.addr = item.char_index;
        store_cmd.data = item.char_code;

        if (fire)
        begin
            res_next = '0;
            unique case (action_t'(item.action))
                ACT_TICK:
                begin
                    // start a pending sequence when idle
                    if (!busy_reg && setup_reg)
                    begin
                        step_eff  = ST_SET1;
                        busy_next = 1'b1;
                    end
                    else if (!busy_reg && print_reg)
                    begin
                        step_eff  = ST_ADDR1;
                        busy_next = 1'b1;
                    end

                    unique case (step_eff)
                        ST_SET1:
                        begin
                            res_next.strobe_res = 1'b1;
                            res_next.bus_byte   = INSTR_CLEAR;
                            step_next           = ST_SET2;
                        end
                        ST_SET2:
                        begin
                            res_next.strobe_res = 1'b1;
                            res_next.bus_byte   = INSTR_DISP;
                            step_next           = ST_SET3;
                        end
                        ST_SET3:
                        begin
                            res_next.strobe_res = 1'b1;
                            res_next.bus_byte   = INSTR_FUNC;
                            step_next           = ST_SET4;
                        end
                        ST_SET4:
                        begin
                            res_next.strobe_res = 1'b1;
                            res_next.bus_byte   = INSTR_ENTRY;
                            step_next           = ST_IDLE;
                            print_next          = 1'b1;
                            setup_next          = 1'b0;
                        end
                        ST_ADDR1:
                        begin
                            res_next.strobe_res = 1'b1;
                            res_next.bus_byte   = INSTR_ROW1;
                            step_next           = ST_ROW1;
                        end
                        ST_ROW1:
                        begin
                            res_next.strobe_res = 1'b1;
                            res_next.bus_byte   = char_byte;
                            res_next.reg_select = 1'b1;
                            pos_next            = pos_inc;
                            if (pos_inc >= ROW_END)
                            begin
                                pos_next  = ROW_END;
                                step_next = ST_ADDR2;
                            end
                        end
                        ST_ADDR2:
                        begin
                            res_next.strobe_res = 1'b1;
                            res_next.bus_byte   = INSTR_ROW2;
                            step_next           = ST_ROW2;
                        end
                        ST_ROW2:
                        begin
                            res_next.strobe_res = 1'b1;
                            res_next.bus_byte   = char_byte;
                            res_next.reg_select = 1'b1;
                            pos_next            = pos_inc;
                            if (pos_inc >= STORE_END)
                            begin
                                step_next  = ST_IDLE;
                                print_next = 1'b0;
                            end
                        end
                        default:
                        begin
                            // idle tick releases busy
                            step_next = ST_IDLE;
                            pos_next  = '0;
                            busy_next = 1'b0;
                        end
                    endcase
                end
                ACT_WRITE:
                begin
                    store_cmd.wr_en = 1'b1;
                end
                ACT_PRINT:
                begin
                    print_next = 1'b1;
                end
                ACT_CLEAR:
                begin
                    store_cmd.clr = 1'b1;
                end
                default:
                begin
                    store_cmd.clr = 1'b0;
                end
            endcase
            res_next.read_write = 1'b0;
            res_next.busy_res   = busy_next;
        end

        if (fire)
        begin
            res_valid_next = 1'b1;
        end
        else if (res_ready)
        begin
            res_valid_next = 1'b0;
        end
        else
        begin
            res_valid_next = res_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= ST_IDLE;
            busy_reg      <= 1'b0;
            setup_reg     <= 1'b1;
            print_reg     <= 1'b0;
            pos_reg       <= '0;
            res_valid_reg <= 1'b0;
            res_reg       <= '0;
        end
        else
        begin
            step_reg      <= step_next;
            busy_reg      <= busy_next;
            setup_reg     <= setup_next;
            print_reg     <= print_next;
            pos_reg       <= pos_next;
            res_valid_reg <= res_valid_next;
            res_reg       <= res_next;
        end
    end

    assign res       = res_reg;
    assign res_valid = res_valid_reg;

    // a running sequence always holds busy
    a_step_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (step_reg != ST_IDLE) |-> busy_reg)
        else $error("sequence step active without busy");

    // setup completion always queues a print
    a_setup_print: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(setup_reg) |-> print_reg)
        else $error("setup ended without print request");

    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= STORE_END)
        else $error("char position past store");

    // a strobed character byte only comes from a row step
    a_rs_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && res_reg.reg_select) |-> res_reg.strobe_res && res_reg.busy_res)
        else $error("character data without strobe or busy");

endmodule

`default_nettype wire

// ----- rtl/char_lcd_init_and_refresh_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none

// a request accepted into the input stage register moves on to the result register, from which
// the output side takes its result
// throughput: one request per cycle, set by the input register and result register
// each taking one request per clock as long as the result side keeps taking results
// reset: asynchronous active low; sequencer idle, setup queued, store filled with spaces
// the first four ticks after reset send the setup instructions, then a print follows

module char_lcd_init_and_refresh_unit
    import clm_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    clm_in_if.sink    in_ch,
    clm_out_if.source out_ch
);

    // input stage register
    logic       s1_valid_reg;
    item_t      s1_item_reg;
    logic       seq_ready;
    logic       in_fire;

    store_cmd_t       store_cmd;
    logic [IDX_W-1:0] rd_addr;
    logic [7:0]       rd_data;
    result_t          res;
    logic             res_valid;

    // input stage takes a new request whenever its current one moves on
    assign in_ch.ready = !s1_valid_reg || seq_ready;
    assign in_fire     = in_ch.valid && in_ch.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (seq_ready)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    // payload register, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_item_reg.action     <= in_ch.action;
            s1_item_reg.char_index <= in_ch.char_index;
            s1_item_reg.char_code  <= in_ch.char_code;
        end
    end

    // character store, written by the sequencer stage
    clm_store u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (store_cmd),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // step sequencer plus result register
    clm_seq u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (s1_item_reg),
        .item_valid (s1_valid_reg),
        .item_ready (seq_ready),
        .store_cmd  (store_cmd),
        .rd_addr    (rd_addr),
        .rd_data    (rd_data),
        .res        (res),
        .res_valid  (res_valid),
        .res_ready  (out_ch.ready)
    );

    assign out_ch.valid      = res_valid;
    assign out_ch.strobe_res = res.strobe_res;
    assign out_ch.bus_byte   = res.bus_byte;
    assign out_ch.reg_select = res.reg_select;
    assign out_ch.read_write = res.read_write;
    assign out_ch.busy_res   = res.busy_res;

    // rw is never driven high
    a_rw_low: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |-> !out_ch.read_write)
        else $error("read_write set on result");

    // a request held in the input stage reaches the result register on a free slot
    a_stage_move: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && seq_ready) |=> out_ch.valid)
        else $error("request lost between stages");

    // without strobe the data lines stay zero
    a_idle_bus: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && !out_ch.strobe_res) |-> (out_ch.bus_byte == 8'h00))
        else $error("bus byte driven without strobe");

endmodule

`default_nettype wire
